@@ sv/i2p_pkg.sv @@
// Shared types, operator codes and character helpers for the infix-to-postfix converter.
package i2p_pkg;

   localparam int I2P_STACK_DEPTH = 32;

   typedef logic [2:0] code_type;

   localparam code_type CODE_LPAREN = 3'd0;
   localparam code_type CODE_PLUS   = 3'd1;
   localparam code_type CODE_MINUS  = 3'd2;
   localparam code_type CODE_TIMES  = 3'd3;
   localparam code_type CODE_DIVIDE = 3'd4;
   localparam code_type CODE_POWER  = 3'd5;

   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_TIMES  = 8'h2A;
   localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
   localparam logic [7:0] CHAR_POWER  = 8'h5E;
   localparam logic [7:0] CHAR_NONE   = 8'h00;

   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

   function automatic logic [7:0] code_char(input code_type code);
      logic [7:0] ch;
      unique case (code)
         CODE_LPAREN: ch = CHAR_LPAREN;
         CODE_PLUS:   ch = CHAR_PLUS;
         CODE_MINUS:  ch = CHAR_MINUS;
         CODE_TIMES:  ch = CHAR_TIMES;
         CODE_DIVIDE: ch = CHAR_DIVIDE;
         CODE_POWER:  ch = CHAR_POWER;
         default:     ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] code_prec(input code_type code);
      logic [1:0] prec;
      unique case (code)
         CODE_TIMES, CODE_DIVIDE: prec = 2'd1;
         CODE_POWER:              prec = 2'd2;
         default:                 prec = 2'd0;
      endcase
      return prec;
   endfunction

   function automatic code_type op_code(input logic [7:0] sym);
      code_type code;
      unique case (sym)
         CHAR_PLUS:   code = CODE_PLUS;
         CHAR_MINUS:  code = CODE_MINUS;
         CHAR_TIMES:  code = CODE_TIMES;
         CHAR_DIVIDE: code = CODE_DIVIDE;
         CHAR_POWER:  code = CODE_POWER;
         default:     code = CODE_LPAREN;
      endcase
      return code;
   endfunction

   function automatic logic is_letter(input logic [7:0] sym);
      return ((sym >= 8'h61) && (sym <= 8'h7A)) || ((sym >= 8'h41) && (sym <= 8'h5A));
   endfunction

endpackage

@@ sv/i2p_if.sv @@
// Valid/ready channel interfaces for the converter's input and result beats.
interface i2p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       end_of_expr;

   modport source (output valid, output symbol, output end_of_expr, input ready);
   modport sink (input valid, input symbol, input end_of_expr, output ready);
endinterface

interface i2p_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_symbol;
   logic       last_of_run;
   logic       overflow_seen;

   modport source (output valid, output out_symbol, output last_of_run,
                   output overflow_seen, input ready);
   modport sink (input valid, input out_symbol, input last_of_run,
                 input overflow_seen, output ready);
endinterface

@@ sv/i2p_cell.sv @@
// One operator stack cell that shifts toward the bottom on push and toward the top on pop.
module i2p_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  i2p_pkg::cell_ctrl_type ctrl,
   input  i2p_pkg::code_type      left_code,
   input  logic                   left_valid,
   input  i2p_pkg::code_type      right_code,
   input  logic                   right_valid,
   output i2p_pkg::code_type      code,
   output logic                   valid
);
   import i2p_pkg::*;

   code_type code_ff;
   logic     valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.push) begin
         valid_ff <= left_valid;
      end else if (ctrl.pop) begin
         valid_ff <= right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         code_ff <= left_code;
      end else if (ctrl.pop) begin
         code_ff <= right_code;
      end
   end

   assign code  = code_ff;
   assign valid = valid_ff;

endmodule

@@ sv/infix_to_postfix_converter_top.sv @@
// Top level of the infix-to-postfix converter: sequencer, output staging and stack chain.
// One symbol is taken per beat when the block is idle. Every item is accepted in the idle state
// and ends in a closing state that hands over its last result; a letter, a '(' or an ignored
// character needs no other step. An operator first pops each entry that it must pop and then
// pushes itself. A ')' first pops each operator above the '(' and then discards the '(' or
// finds none. An end of expression first flushes each entry and then sees the empty stack.
// The row of stack cells moves one entry per cycle while a push or pop is issued. Results
// leave through a one-beat holding stage and an output register, so a stalled result side
// holds the sequencer only when both are full.
// The stack holds STACK_DEPTH entries in a row of cells whose valid bits form the count.
module infix_to_postfix_converter_top #(
   parameter int STACK_DEPTH = i2p_pkg::I2P_STACK_DEPTH
) (
   input logic        clock,
   input logic        reset,
   i2p_req_if.sink    req,
   i2p_rsp_if.source  rsp
);
   import i2p_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_POP_OP = 5'b00010,
      ST_POP_RP = 5'b00100,
      ST_FLUSH  = 5'b01000,
      ST_DRAIN  = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   code_type      op_ff, op_in;
   logic          fin_ff, fin_in;
   logic          ovf_ff;
   logic          pend_valid_ff;
   logic [7:0]    pend_sym_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_sym_ff;
   logic          rsp_last_ff;
   logic          rsp_ovf_ff;

   cell_ctrl_type ctrl;
   code_type      new_code;
   code_type      cell_code  [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] cell_valid;

   logic          out_free, can_emit;
   logic          emit_en, send_last, ovf_set, ovf_clr;
   logic [7:0]    emit_sym;
   logic          top_valid, full;
   code_type      top_code;
   code_type      req_op;
   state_type     after_sym;

   assign top_valid = cell_valid[0];
   assign top_code  = cell_code[0];
   assign full      = cell_valid[STACK_DEPTH-1];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign can_emit  = !pend_valid_ff || out_free;
   assign req_op    = op_code(req.symbol);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      fin_in    = fin_ff;
      ctrl      = '0;
      new_code  = op_ff;
      emit_en   = 1'b0;
      emit_sym  = code_char(top_code);
      send_last = 1'b0;
      ovf_set   = 1'b0;
      ovf_clr   = 1'b0;
      after_sym = fin_ff ? ST_FLUSH : ST_DRAIN;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               fin_in    = req.end_of_expr;
               op_in     = req_op;
               after_sym = req.end_of_expr ? ST_FLUSH : ST_DRAIN;
               priority if (is_letter(req.symbol)) begin
                  emit_en  = 1'b1;
                  emit_sym = req.symbol;
                  state_in = after_sym;
               end else if (req_op != CODE_LPAREN) begin
                  state_in = ST_POP_OP;
               end else if (req.symbol == CHAR_LPAREN) begin
                  new_code = CODE_LPAREN;
                  if (full) begin
                     ovf_set = 1'b1;
                  end else begin
                     ctrl.push = 1'b1;
                  end
                  state_in = after_sym;
               end else if (req.symbol == CHAR_RPAREN) begin
                  state_in = ST_POP_RP;
               end else begin
                  state_in = after_sym;
               end
            end
         end
         ST_POP_OP: begin
            if (top_valid && (top_code != CODE_LPAREN) &&
                (code_prec(top_code) >= code_prec(op_ff))) begin
               if (can_emit) begin
                  emit_en  = 1'b1;
                  ctrl.pop = 1'b1;
               end
            end else begin
               if (full) begin
                  ovf_set = 1'b1;
               end else begin
                  ctrl.push = 1'b1;
               end
               state_in = after_sym;
            end
         end
         ST_POP_RP: begin
            if (top_valid && (top_code != CODE_LPAREN)) begin
               if (can_emit) begin
                  emit_en  = 1'b1;
                  ctrl.pop = 1'b1;
               end
            end else begin
               ctrl.pop = top_valid;
               state_in = after_sym;
            end
         end
         ST_FLUSH: begin
            if (!top_valid) begin
               state_in = ST_DRAIN;
            end else if (top_code == CODE_LPAREN) begin
               ctrl.pop = 1'b1;
            end else if (can_emit) begin
               emit_en  = 1'b1;
               ctrl.pop = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!pend_valid_ff) begin
               ovf_clr  = fin_ff;
               state_in = ST_IDLE;
            end else if (out_free) begin
               send_last = 1'b1;
               ovf_clr   = fin_ff;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ovf_clr) begin
            ovf_ff <= 1'b0;
         end else if (ovf_set) begin
            ovf_ff <= 1'b1;
         end
         if (emit_en) begin
            pend_valid_ff <= 1'b1;
         end else if (send_last) begin
            pend_valid_ff <= 1'b0;
         end
         if ((emit_en && pend_valid_ff) || send_last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      fin_ff <= fin_in;
      if (emit_en) begin
         pend_sym_ff <= emit_sym;
      end
      if ((emit_en && pend_valid_ff) || send_last) begin
         rsp_sym_ff  <= pend_sym_ff;
         rsp_last_ff <= send_last;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      code_type left_code, right_code;
      logic     left_valid, right_valid;

      if (i == 0) begin : g_head
         assign left_code  = new_code;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_code  = cell_code[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_tail
         assign right_code  = CODE_LPAREN;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_code  = cell_code[i+1];
         assign right_valid = cell_valid[i+1];
      end

      i2p_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_code   (left_code),
         .left_valid  (left_valid),
         .right_code  (right_code),
         .right_valid (right_valid),
         .code        (cell_code[i]),
         .valid       (cell_valid[i])
      );
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_symbol    = rsp_sym_ff;
   assign rsp.last_of_run   = rsp_last_ff;
   assign rsp.overflow_seen = rsp_ovf_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("A pending beat is left over while the converter is idle.");

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && ctrl.pop))
      else $error("The stack is pushed and popped in the same cycle.");

   a_stack_packed: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid & (cell_valid >> 1)) == (cell_valid >> 1)))
      else $error("The stack cells hold a gap below the top.");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> !full)
      else $error("A push was issued onto a full stack.");

endmodule
